FILE: hdl/bcdte_pkg.sv
// ----------------------------------------------------------------------------
// bcdte_pkg: shared types and constants for the RTC to epoch converter
// Holds the decoded calendar word, the time-scale constants and the
// cumulative month-length table.
// ----------------------------------------------------------------------------
package bcdte_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned EpochW    = 63;

  // Time scale constants.
  localparam logic [16:0] SecPerDay = 17'd86400;
  localparam logic [11:0] SecPerHr  = 12'd3600;
  localparam logic [5:0]  SecPerMin = 6'd60;
  localparam logic [29:0] NsPerSec  = 30'd1000000000;
  localparam logic [8:0]  DaysPerYr = 9'd365;

  // Years from 1970 to 2000, and leap years 1972..1996 in that span.
  localparam logic [8:0]  YearsTo2000 = 9'd30;
  localparam logic [6:0]  LeapsTo2000 = 7'd7;

  // Two-digit years whose century years are not leap years (2100, 2200).
  localparam logic [7:0]  Century1 = 8'd100;
  localparam logic [7:0]  Century2 = 8'd200;

  localparam logic [7:0]  MonthJan = 8'd1;
  localparam logic [7:0]  MonthFeb = 8'd2;
  localparam logic [7:0]  MonthDec = 8'd12;

  // One decoded set of calendar fields.
  typedef struct packed {
    logic [ByteW-1:0] sec;
    logic [ByteW-1:0] min;
    logic [ByteW-1:0] hour;
    logic [ByteW-1:0] day;
    logic [ByteW-1:0] mon;
    logic [ByteW-1:0] year;
    logic             month_err;
  } decode_t;

  // Days in the months before the given month of a common year.
  function automatic logic [8:0] days_before_month(input logic [ByteW-1:0] mon);
    logic [8:0] d;
    case (mon)
      8'd1:    d = 9'd0;
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/bcdte_decode.sv
// ----------------------------------------------------------------------------
// bcdte_decode: register byte decoder
// Turns the six RTC bytes into binary values, BCD or pass-through, and
// flags a month outside January to December.
// ----------------------------------------------------------------------------
module bcdte_decode (
  input  logic [7:0]        raw_seconds_i,
  input  logic [7:0]        raw_minutes_i,
  input  logic [7:0]        raw_hours_i,
  input  logic [7:0]        raw_day_i,
  input  logic [7:0]        raw_month_i,
  input  logic [7:0]        raw_year_i,
  input  logic              binary_mode_i,
  output bcdte_pkg::decode_t dec_o
);
  import bcdte_pkg::*;

  // Nibbles above nine are not rejected; they decode arithmetically.
  function automatic logic [ByteW-1:0] dec_byte(input logic [ByteW-1:0] b,
                                                 input logic bin);
    logic [ByteW-1:0] lo;
    logic [ByteW-1:0] hi;
    lo = {4'b0, b[3:0]};
    hi = {4'b0, b[7:4]};
    return bin ? b : (lo + (hi << 3) + (hi << 1));
  endfunction

  always_comb begin
    dec_o.sec       = dec_byte(raw_seconds_i, binary_mode_i);
    dec_o.min       = dec_byte(raw_minutes_i, binary_mode_i);
    dec_o.hour      = dec_byte(raw_hours_i,   binary_mode_i);
    dec_o.day       = dec_byte(raw_day_i,     binary_mode_i);
    dec_o.mon       = dec_byte(raw_month_i,   binary_mode_i);
    dec_o.year      = dec_byte(raw_year_i,    binary_mode_i);
    dec_o.month_err = (dec_o.mon < MonthJan) || (dec_o.mon > MonthDec);
  end

endmodule

FILE: hdl/bcd_rtc_to_epoch_ns.sv
// ----------------------------------------------------------------------------
// bcd_rtc_to_epoch_ns: RTC calendar registers to Unix time in nanoseconds
// Five-stage pipeline from raw clock bytes to nanoseconds since 1970.
// ----------------------------------------------------------------------------
// The block takes one word of RTC register bytes (seconds, minutes, hours,
// day, month and a two-digit year counted from 2000) in BCD or plain binary
// and returns the nanoseconds since 1970-01-01 UTC, or zero with
// month_error_o set when the decoded month is not 1 to 12. Field values are
// otherwise unchecked: a day of zero is one day before the first of the
// month and out-of-range times simply add in. A new word is taken in every
// cycle while stall_o is low. Its result passes through the five register
// stages (byte decode, calendar terms, seconds, split 17x30 bit nanosecond
// multiply, final add), the first of which loads at the accepting edge.
// A stall on the output backs up through the stages without losing or
// repeating a word, and stall_o rises only when every stage is holding
// a word.
module bcd_rtc_to_epoch_ns (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  raw_seconds_i,
  input  logic [7:0]  raw_minutes_i,
  input  logic [7:0]  raw_hours_i,
  input  logic [7:0]  raw_day_i,
  input  logic [7:0]  raw_month_i,
  input  logic [7:0]  raw_year_i,
  input  logic        binary_mode_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [62:0] epoch_ns_o,
  output logic        month_error_o
);
  import bcdte_pkg::*;

  // Stage valid bits and the ready chain. A stage takes a new word when it
  // is empty or the stage after it is moving.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  assign r5 = !v5_q || !stall_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign stall_o = !r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // Stage 1: byte decode.
  decode_t dec_d, dec_q;

  bcdte_decode u_decode (
    .raw_seconds_i (raw_seconds_i),
    .raw_minutes_i (raw_minutes_i),
    .raw_hours_i   (raw_hours_i),
    .raw_day_i     (raw_day_i),
    .raw_month_i   (raw_month_i),
    .raw_year_i    (raw_year_i),
    .binary_mode_i (binary_mode_i),
    .dec_o         (dec_d)
  );

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) dec_q <= dec_d;
  end

  // Stage 2: days up to January 1 of the year, days into the year plus the
  // day of month, and the time of day in seconds. Within 2000..2255 the
  // leap years after 1999 are every fourth one, less 2100 and 2200.
  logic [8:0]  yr_span;
  logic [8:0]  yr_round;
  logic [6:0]  leaps;
  logic        leap_year;
  logic [16:0] ydays_d, ydays_q;
  logic [9:0]  mdays_d, mdays_q;
  logic [19:0] hms_d, hms_q;
  logic        err2_q;

  always_comb begin
    yr_span   = {1'b0, dec_q.year} + YearsTo2000;
    yr_round  = {1'b0, dec_q.year} + 9'd3;
    leaps     = LeapsTo2000 + yr_round[8:2]
              - {6'b0, (dec_q.year > Century1)}
              - {6'b0, (dec_q.year > Century2)};
    leap_year = (dec_q.year[1:0] == 2'b00) && (dec_q.year != Century1)
                && (dec_q.year != Century2);
    ydays_d   = 17'({8'b0, yr_span} * {8'b0, DaysPerYr}) + {10'b0, leaps};
    mdays_d   = {1'b0, days_before_month(dec_q.mon)}
              + {9'b0, (leap_year && (dec_q.mon > MonthFeb))}
              + {2'b0, dec_q.day};
    hms_d     = 20'({12'b0, dec_q.hour} * {8'b0, SecPerHr})
              + 20'({12'b0, dec_q.min} * {14'b0, SecPerMin})
              + {12'b0, dec_q.sec};
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      ydays_q <= ydays_d;
      mdays_q <= mdays_d;
      hms_q   <= hms_d;
      err2_q  <= dec_q.month_err;
    end
  end

  // Stage 3: whole seconds. Days never underflow, the year term is at
  // least thirty years.
  logic [16:0] days;
  logic [33:0] secs_d, secs_q;
  logic        err3_q;

  always_comb begin
    days   = ydays_q + {7'b0, mdays_q} - 17'd1;
    secs_d = ({17'b0, days} * {17'b0, SecPerDay}) + {14'b0, hms_q};
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      secs_q <= secs_d;
      err3_q <= err2_q;
    end
  end

  // Stage 4: the seconds split into two 17-bit halves, each scaled by
  // one billion.
  logic [46:0] plo_d, plo_q, phi_d, phi_q;
  logic        err4_q;

  assign plo_d = {30'b0, secs_q[16:0]}  * {17'b0, NsPerSec};
  assign phi_d = {30'b0, secs_q[33:17]} * {17'b0, NsPerSec};

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      err4_q <= err3_q;
    end
  end

  // Stage 5: recombine the halves into the output register; an invalid
  // month forces the result to zero.
  logic [63:0]       ns_sum;
  logic [EpochW-1:0] ns_d, ns_q;
  logic              err5_q;

  always_comb begin
    ns_sum = {17'b0, plo_q} + {phi_q, 17'b0};
    ns_d   = err4_q ? '0 : ns_sum[EpochW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      ns_q   <= ns_d;
      err5_q <= err4_q;
    end
  end

  assign valid_o       = v5_q;
  assign epoch_ns_o    = ns_q;
  assign month_error_o = err5_q;

  // A flagged word always carries a zero time.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && month_error_o |-> epoch_ns_o == '0)
    else $error("month error with nonzero time");

  // A good word is never earlier than the last day of 1999.
  a_lower_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !month_error_o |-> epoch_ns_o >= 63'd946598400000000000)
    else $error("time below the representable range");

  // Back-pressure reaches the input only with the whole pipeline full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> v1_q && v2_q && v3_q && v4_q && v5_q && stall_i)
    else $error("input stalled with an empty stage");

  // An accepted word lands in the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> v1_q)
    else $error("accepted word lost at entry");

endmodule
